FILE: sv/wcef_pkg.sv
// shared types, constants and helper functions for the window change escape filter
`default_nettype none
package wcef_pkg;

    // sequence and packet-header constants
    localparam logic [7:0] MAGIC_BYTE       = 8'hFF;
    localparam logic [7:0] CMD_BYTE         = 8'h73;
    localparam logic [7:0] WINDOW_BIT       = 8'h80;
    localparam logic [7:0] PKT_CONTROL_MASK = 8'h32;
    localparam logic [3:0] SEQ_LEN          = 4'd12;
    localparam logic [3:0] PREFIX_LEN       = 4'd4;
    localparam logic [3:0] MAGIC_LEN        = 4'd2;

    // result kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_URGENT = 2'd1;
    localparam logic [1:0] KIND_WINDOW = 2'd2;

    // command queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // back end expansion phases, in emission order
    localparam logic [2:0] PH_PRE   = 3'd0;
    localparam logic [2:0] PH_BYTE  = 3'd1;
    localparam logic [2:0] PH_WIN   = 3'd2;
    localparam logic [2:0] PH_FLUSH = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;

    // one classified input: prefix bytes, single byte, window update, flush
    typedef struct packed {
        logic [1:0]  pre_cnt;
        logic        has_byte;
        logic [1:0]  byte_kind;
        logic [7:0]  byte_val;
        logic        has_win;
        logic [3:0]  flush_cnt;
        logic [63:0] payload;
    } wcef_cmd_t;

    // queue status seen by the top level
    typedef struct packed {
        logic [QCW-1:0] count;
        logic           full;
        logic           empty;
    } wcef_qstat_t;

    // true if the phase emits anything for this command
    function automatic logic phase_busy(input wcef_cmd_t cmd, input logic [2:0] ph);
        logic res;
        case (ph)
            PH_PRE:   res = (cmd.pre_cnt != 2'd0);
            PH_BYTE:  res = cmd.has_byte;
            PH_WIN:   res = cmd.has_win;
            PH_FLUSH: res = (cmd.flush_cnt != 4'd0);
            default:  res = 1'b0;
        endcase
        return res;
    endfunction

    // first phase at or after start that emits something
    function automatic logic [2:0] first_phase(input wcef_cmd_t cmd, input logic [2:0] start);
        logic [2:0] res;
        res = PH_DONE;
        for (int k = 3; k >= 0; k--) begin
            if (k >= int'(start) && phase_busy(cmd, 3'(k))) begin
                res = 3'(k);
            end
        end
        return res;
    endfunction

    // byte at position idx of the held sequence
    function automatic logic [7:0] held_byte(input logic [3:0] idx, input logic [63:0] payload);
        logic [3:0] off;
        logic [7:0] res;
        off = idx - PREFIX_LEN;
        if (idx < MAGIC_LEN) begin
            res = MAGIC_BYTE;
        end else if (idx < PREFIX_LEN) begin
            res = CMD_BYTE;
        end else begin
            res = payload[8*off[2:0] +: 8];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: sv/window_change_escape_filter.sv
// Window change escape filter: top level joining front end, command queue and back end.
// An accepted request is stored in the queue, then in the back end's output register.
// Throughput: one input per cycle while m_ready holds and each yields at most one result;
// an input with several results holds the back end, which emits them one per cycle.
// The four-entry command queue lets input flow on while the back end expands a burst.
// Reset (aresetn low, synchronous): match cleared, queue emptied, window flag set to one.
`default_nettype none
module window_change_escape_filter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_func,
    input  wire logic [7:0]  s_in_byte,
    input  wire logic        s_chunk_end,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_out_kind,
    output logic [7:0]       m_out_byte,
    output logic [15:0]      m_rows,
    output logic [15:0]      m_cols,
    output logic [15:0]      m_width_pixels,
    output logic [15:0]      m_height_pixels,
    output logic             m_last
);
    import wcef_pkg::*;

    wcef_cmd_t   f_cmd, q_head;
    wcef_qstat_t q_stat;
    logic        f_push, q_valid, q_ready, q_pop, accept;

    assign s_ready = q_ready;
    assign accept  = s_valid && q_ready;

    // classifier
    wcef_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .func      (s_func),
        .in_byte   (s_in_byte),
        .chunk_end (s_chunk_end),
        .push      (f_push),
        .cmd       (f_cmd)
    );

    // command queue
    wcef_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (f_push),
        .push_cmd   (f_cmd),
        .pop        (q_pop),
        .head       (q_head),
        .head_valid (q_valid),
        .in_ready   (q_ready),
        .stat       (q_stat)
    );

    // result expander
    wcef_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_cmd           (q_head),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_kind      (m_out_kind),
        .m_out_byte      (m_out_byte),
        .m_rows          (m_rows),
        .m_cols          (m_cols),
        .m_width_pixels  (m_width_pixels),
        .m_height_pixels (m_height_pixels),
        .m_last          (m_last)
    );

`ifndef NO_ASSERTIONS
    // queue never overfills
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.count <= QCW'(QDEPTH))
        else $error("command queue count beyond depth");

    // window updates and urgent bytes always close their input's results
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_out_kind == KIND_WINDOW || m_out_kind == KIND_URGENT) |-> m_last)
        else $error("window or urgent result not marked last");

    // window fields stay zero on byte results
    a_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_kind != KIND_WINDOW |->
            m_rows == 16'h0000 && m_cols == 16'h0000 &&
            m_width_pixels == 16'h0000 && m_height_pixels == 16'h0000)
        else $error("window fields set on a byte result");

    // nothing offered right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered after reset");
`endif

endmodule
`default_nettype wire

FILE: sv/wcef_front.sv
// front end: sequence matcher and classifier that turns each input into a command
`default_nettype none
module wcef_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic              func,
    input  wire logic [7:0]        in_byte,
    input  wire logic              chunk_end,
    output logic                   push,
    output wcef_pkg::wcef_cmd_t    cmd
);
    import wcef_pkg::*;

    logic [3:0]  match_reg, match_next;
    logic [63:0] pay_reg, pay_next;
    logic        unacked_reg, unacked_next;
    logic [3:0]  match_step;
    logic [3:0]  widx_full;
    wcef_cmd_t   c;

    // classify one request against the current match state
    always_comb begin
        c            = '0;
        c.byte_kind  = KIND_DATA;
        c.byte_val   = in_byte;
        pay_next     = pay_reg;
        unacked_next = unacked_reg;
        match_step   = match_reg;
        widx_full    = match_reg - PREFIX_LEN;
        if (func) begin
            c.byte_kind = KIND_URGENT;
            c.byte_val  = in_byte | (unacked_reg ? WINDOW_BIT : 8'h00);
            c.has_byte  = (in_byte != 8'h00) && ((in_byte & PKT_CONTROL_MASK) != 8'h00);
        end else begin
            case (match_reg)
                4'd0: begin
                    if (in_byte == MAGIC_BYTE) begin
                        match_step = 4'd1;
                    end else begin
                        c.has_byte = 1'b1;
                    end
                end
                4'd1: begin
                    if (in_byte == MAGIC_BYTE) begin
                        match_step = 4'd2;
                    end else begin
                        c.pre_cnt  = 2'd1;
                        c.has_byte = 1'b1;
                        match_step = 4'd0;
                    end
                end
                4'd2: begin
                    if (in_byte == CMD_BYTE) begin
                        match_step = 4'd3;
                    end else if (in_byte == MAGIC_BYTE) begin
                        c.pre_cnt = 2'd1;
                    end else begin
                        c.pre_cnt  = 2'd2;
                        c.has_byte = 1'b1;
                        match_step = 4'd0;
                    end
                end
                4'd3: begin
                    if (in_byte == CMD_BYTE) begin
                        match_step = 4'd4;
                    end else begin
                        c.pre_cnt = 2'd3;
                        if (in_byte == MAGIC_BYTE) begin
                            match_step = 4'd1;
                        end else begin
                            c.has_byte = 1'b1;
                            match_step = 4'd0;
                        end
                    end
                end
                default: begin
                    // payload byte: store it, finish the sequence on the last one
                    pay_next[8*widx_full[2:0] +: 8] = in_byte;
                    match_step = match_reg + 4'd1;
                    if (match_step >= SEQ_LEN) begin
                        c.has_win    = 1'b1;
                        unacked_next = 1'b0;
                        match_step   = 4'd0;
                    end
                end
            endcase
        end
        // chunk end flushes whatever is still held, except on a function request
        match_next = match_step;
        if (!func && chunk_end) begin
            c.flush_cnt = match_step;
            match_next  = 4'd0;
        end
        c.payload = pay_next;
    end

    assign cmd  = c;
    assign push = accept && (c.pre_cnt != 2'd0 || c.has_byte || c.has_win ||
                             c.flush_cnt != 4'd0);

    // match state and window flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg   <= 4'd0;
            unacked_reg <= 1'b1;
        end else if (accept) begin
            match_reg   <= match_next;
            unacked_reg <= unacked_next;
        end
    end

    // payload bytes of the current match
    always_ff @(posedge aclk) begin
        if (accept) begin
            pay_reg <= pay_next;
        end
    end

endmodule
`default_nettype wire

FILE: sv/wcef_queue.sv
// short command queue between the front and back ends
`default_nettype none
module wcef_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire wcef_pkg::wcef_cmd_t  push_cmd,
    input  wire logic                 pop,
    output wcef_pkg::wcef_cmd_t       head,
    output logic                      head_valid,
    output logic                      in_ready,
    output wcef_pkg::wcef_qstat_t     stat
);
    import wcef_pkg::*;

    wcef_cmd_t        mem_reg [QDEPTH];
    logic [QAW-1:0]   wptr_reg, rptr_reg;
    logic [QCW-1:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign in_ready   = (count_reg != QCW'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rptr_reg];
    assign do_push    = push && in_ready;
    assign do_pop     = pop && head_valid;

    assign stat.count = count_reg;
    assign stat.full  = !in_ready;
    assign stat.empty = !head_valid;

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCW'(1);
        end else if (!do_push && do_pop) begin
            count_next = count_reg - QCW'(1);
        end
    end

    // pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wptr_reg <= wptr_reg + QAW'(1);
            end
            if (do_pop) begin
                rptr_reg <= rptr_reg + QAW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

FILE: sv/wcef_back.sv
// back end: expands commands, one result per cycle unless stalled, to an output register
`default_nettype none
module wcef_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 q_valid,
    input  wire wcef_pkg::wcef_cmd_t  q_cmd,
    output logic                      q_pop,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [1:0]                m_out_kind,
    output logic [7:0]                m_out_byte,
    output logic [15:0]               m_rows,
    output logic [15:0]               m_cols,
    output logic [15:0]               m_width_pixels,
    output logic [15:0]               m_height_pixels,
    output logic                      m_last
);
    import wcef_pkg::*;

    wcef_cmd_t   cur_reg;
    logic        cur_valid_reg, cur_valid_next;
    logic [2:0]  ph_reg, ph_next;
    logic [3:0]  pos_reg, pos_next;

    wcef_cmd_t   act_cmd;
    logic        act_valid;
    logic [2:0]  act_ph;
    logic [3:0]  act_pos, pos_inc;
    logic        slot_free, emit, stay, is_last;

    logic        m_valid_reg;
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  byte_reg, byte_next;
    logic [15:0] rows_reg, cols_reg, wpix_reg, hpix_reg;
    logic [15:0] rows_next, cols_next, wpix_next, hpix_next;
    logic        last_reg;

    // pick the command in progress, or the queue head to start a new one
    assign slot_free = !m_valid_reg || m_ready;
    assign act_valid = cur_valid_reg || q_valid;
    assign act_cmd   = cur_valid_reg ? cur_reg : q_cmd;
    assign act_ph    = cur_valid_reg ? ph_reg : first_phase(q_cmd, PH_PRE);
    assign act_pos   = cur_valid_reg ? pos_reg : 4'd0;
    assign emit      = slot_free && act_valid;
    assign q_pop     = emit && !cur_valid_reg;

    // step to the next position or phase
    always_comb begin
        pos_inc = act_pos + 4'd1;
        stay    = (act_ph == PH_PRE && pos_inc < {2'b00, act_cmd.pre_cnt}) ||
                  (act_ph == PH_FLUSH && pos_inc < act_cmd.flush_cnt);
        ph_next = stay ? act_ph : first_phase(act_cmd, act_ph + 3'd1);
        pos_next = stay ? pos_inc : 4'd0;
        is_last  = (ph_next == PH_DONE);
        cur_valid_next = !is_last;
    end

    // result fields for the current position
    always_comb begin
        kind_next = KIND_DATA;
        byte_next = 8'h00;
        rows_next = 16'h0000;
        cols_next = 16'h0000;
        wpix_next = 16'h0000;
        hpix_next = 16'h0000;
        case (act_ph)
            PH_PRE, PH_FLUSH: begin
                byte_next = held_byte(act_pos, act_cmd.payload);
            end
            PH_BYTE: begin
                kind_next = act_cmd.byte_kind;
                byte_next = act_cmd.byte_val;
            end
            PH_WIN: begin
                kind_next = KIND_WINDOW;
                rows_next = {act_cmd.payload[7:0],   act_cmd.payload[15:8]};
                cols_next = {act_cmd.payload[23:16], act_cmd.payload[31:24]};
                wpix_next = {act_cmd.payload[39:32], act_cmd.payload[47:40]};
                hpix_next = {act_cmd.payload[55:48], act_cmd.payload[63:56]};
            end
            default: begin
                kind_next = KIND_DATA;
            end
        endcase
    end

    // expansion control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (emit) begin
                cur_valid_reg <= cur_valid_next;
            end
            if (slot_free) begin
                m_valid_reg <= emit;
            end
        end
    end

    // command in progress and output payload
    always_ff @(posedge aclk) begin
        if (emit) begin
            cur_reg  <= act_cmd;
            ph_reg   <= ph_next;
            pos_reg  <= pos_next;
            kind_reg <= kind_next;
            byte_reg <= byte_next;
            rows_reg <= rows_next;
            cols_reg <= cols_next;
            wpix_reg <= wpix_next;
            hpix_reg <= hpix_next;
            last_reg <= is_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_kind      = kind_reg;
    assign m_out_byte      = byte_reg;
    assign m_rows          = rows_reg;
    assign m_cols          = cols_reg;
    assign m_width_pixels  = wpix_reg;
    assign m_height_pixels = hpix_reg;
    assign m_last          = last_reg;

endmodule
`default_nettype wire
